### rtl/core/dssfg_pkg.sv
// Shared types, constants and segment table for the decimal seven-segment frame generator.
`default_nettype none

package dssfg_pkg;

   // Field widths
   localparam int MAG_W   = 40;
   localparam int PREC_W  = 4;
   localparam int IMAGE_W = 48;
   localparam int PLACE_W = 4;

   // Display geometry
   localparam int DIGITS_PER_MODULE = 4;
   localparam int SLOT_W            = 16;
   localparam int IMAGE_SLOTS       = IMAGE_W / SLOT_W;
   localparam int RESULT_LIMIT      = 12;

   // BCD conversion: 13 decimal digits cover any 40-bit magnitude
   localparam int BCD_DIGITS = 13;
   localparam int CONV_CNT_W = $clog2(MAG_W);
   localparam int TOTAL_W    = 5;

   // Segment codes, active low
   localparam logic [7:0] SEG_MINUS  = 8'hBF;
   localparam logic [7:0] POINT_MASK = 8'h7F;

   typedef logic [3:0] bcd_digit_type;
   typedef logic [7:0] seg_type;

   // Active-low segment pattern of one decimal digit
   function automatic seg_type seg_of_digit(input bcd_digit_type d);
      seg_type s;
      case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = 8'hFF;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/core/dssfg_if.sv
// Valid/ready channel interfaces for number input, frame output and precision writes.
`default_nettype none

interface dssfg_req_if
   import dssfg_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic             negative;

   modport source (output valid, output magnitude, output negative, input ready);
   modport sink   (input valid, input magnitude, input negative, output ready);
endinterface

interface dssfg_rsp_if
   import dssfg_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [IMAGE_W-1:0] chain_image;
   logic [PLACE_W-1:0] digit_place;
   logic               overflow;
   logic               last;

   modport source (output valid, output chain_image, output digit_place,
                   output overflow, output last, input ready);
   modport sink   (input valid, input chain_image, input digit_place,
                   input overflow, input last, output ready);
endinterface

interface dssfg_csr_if
   import dssfg_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [PREC_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/decimal_seven_segment_frame_gen.sv
// Top level: bit-serial BCD conversion, digit count scan and per-place frame output.
// Flow: bit-serial binary-to-BCD conversion by a one-bit-per-cycle double-dabble shift
//   register, a digit scan down from the top digit, then one frame per cycle while the
//   output is free; output stalls hold the frames. A new number is taken only in idle,
//   once the last frame of the previous one has been registered.
// Reset (synchronous, active high) returns to idle, drops any pending frame, precision 0.
`default_nettype none

module decimal_seven_segment_frame_gen
   import dssfg_pkg::*;
#(
   parameter int MODULES = 3
) (
   input  wire            clock,
   input  wire            reset,
   dssfg_req_if.sink      req,
   dssfg_rsp_if.source    rsp,
   dssfg_csr_if.sink      csr
);

   localparam int PLACES      = MODULES * DIGITS_PER_MODULE;
   localparam int PLACE_LIMIT = (PLACES < RESULT_LIMIT) ? PLACES : RESULT_LIMIT;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [PREC_W-1:0]     prec_ff;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [CONV_CNT_W-1:0] cnt_ff, cnt_in;
   bcd_digit_type         bcd_ff [BCD_DIGITS];
   bcd_digit_type         bcd_in [BCD_DIGITS];
   bcd_digit_type         bcd_adj [BCD_DIGITS];
   logic [3:0]            scan_ff, scan_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [PLACE_W-1:0]    place_ff, place_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IMAGE_W-1:0]    image_ff, image_in;
   logic [PLACE_W-1:0]    oplace_ff, oplace_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;

   logic                  rsp_free;
   logic [3:0]            rd_idx;
   bcd_digit_type         rd_digit;
   logic [3:0]            emit_idx;
   logic [TOTAL_W-1:0]    nd;
   logic [TOTAL_W-1:0]    prec_plus;
   logic [TOTAL_W-1:0]    shown;
   logic                  too_many;
   logic                  emit_last;
   seg_type               seg;
   logic [SLOT_W-1:0]     word;

   // Precision register, written whenever the port offers it
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff <= '0;
      end else if (csr.valid) begin
         prec_ff <= csr.data;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // Add three to every digit of five or more before each shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // Single digit read port, shared by scan and emit
   assign emit_idx = 4'(total_ff - TOTAL_W'(1) - TOTAL_W'(place_ff));
   assign rd_idx   = (state_ff == ST_SCAN) ? scan_ff : emit_idx;
   assign rd_digit = bcd_ff[rd_idx];

   // Shown digits and total places once the top nonzero digit is found
   assign nd        = TOTAL_W'(scan_ff) + TOTAL_W'(1);
   assign prec_plus = TOTAL_W'(prec_ff) + TOTAL_W'(1);
   assign shown     = (nd > prec_plus) ? nd : prec_plus;
   assign too_many  = (total_ff > TOTAL_W'(PLACE_LIMIT));
   assign emit_last = (TOTAL_W'(place_ff) + TOTAL_W'(1) == total_ff);

   // Segment byte of the current place
   always_comb begin
      if (neg_ff && place_ff == '0) begin
         seg = SEG_MINUS;
      end else begin
         seg = seg_of_digit(rd_digit);
         if (emit_idx == prec_ff) begin
            seg = seg & POINT_MASK;
         end
      end
   end

   // Segment byte on top, one-hot select in the low nibble of the low byte
   assign word = {seg, 4'd0, 4'd1 << place_ff[1:0]};

   // Sequencer: convert, scan, then emit one frame per free output slot, or a lone overflow frame
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      bcd_in       = bcd_ff;
      scan_in      = scan_ff;
      total_in     = total_ff;
      place_in     = place_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      image_in     = image_ff;
      oplace_in    = oplace_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mag_in   = req.magnitude;
               neg_in   = req.negative;
               cnt_in   = '0;
               for (int i = 0; i < BCD_DIGITS; i++) begin
                  bcd_in[i] = '0;
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // Shift one magnitude bit into the BCD register
            bcd_in[0] = {bcd_adj[0][2:0], mag_ff[MAG_W-1]};
            for (int i = 1; i < BCD_DIGITS; i++) begin
               bcd_in[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
            end
            mag_in = {mag_ff[MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + CONV_CNT_W'(1);
            if (cnt_ff == CONV_CNT_W'(MAG_W - 1)) begin
               scan_in  = 4'(BCD_DIGITS - 1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Walk down from the top digit to the first nonzero one
            if (rd_digit != '0 || scan_ff == '0) begin
               total_in = shown + TOTAL_W'(neg_ff);
               place_in = '0;
               state_in = ST_EMIT;
            end else begin
               scan_in = scan_ff - 4'd1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (too_many) begin
                  image_in  = '0;
                  oplace_in = '0;
                  ovf_in    = 1'b1;
                  last_in   = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  for (int s = 0; s < IMAGE_SLOTS; s++) begin
                     image_in[s*SLOT_W +: SLOT_W] =
                        (place_ff[PLACE_W-1:2] == 2'(s) && s < MODULES) ? word : '0;
                  end
                  oplace_in = place_ff;
                  ovf_in    = 1'b0;
                  last_in   = emit_last;
                  place_in  = place_ff + PLACE_W'(1);
                  if (emit_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      bcd_ff    <= bcd_in;
      scan_ff   <= scan_in;
      total_ff  <= total_in;
      place_ff  <= place_in;
      image_ff  <= image_in;
      oplace_ff <= oplace_in;
      ovf_ff    <= ovf_in;
      last_ff   <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.chain_image = image_ff;
   assign rsp.digit_place = oplace_ff;
   assign rsp.overflow    = ovf_ff;
   assign rsp.last        = last_ff;

   // An overflow transaction is a lone, blank, final frame
   a_ovf_blank : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.overflow |-> rsp.last && rsp.chain_image == '0
         && rsp.digit_place == '0)
      else $error("overflow frame not blank or not last");

   // Frames stay within the usable places
   a_place_range : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.overflow |-> rsp.digit_place < PLACE_W'(PLACE_LIMIT))
      else $error("frame place beyond display");

   // No new number is taken while one is in progress
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("input accepted while busy");

   // A normal frame of the first module lights exactly one select line
   a_one_select : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.overflow && rsp.digit_place < PLACE_W'(4)
         |-> $onehot(rsp.chain_image[3:0]))
      else $error("select not one-hot");

endmodule

`default_nettype wire
